### src/sampled_dc_variance_pulse_meter_core_defines.svh
// Assertion macros used by the meter core RTL.
`ifndef SAMPLED_DC_VARIANCE_PULSE_METER_CORE_DEFINES_SVH
`define SAMPLED_DC_VARIANCE_PULSE_METER_CORE_DEFINES_SVH

// Checks a condition against another in the same cycle, outside reset.
`define SDVPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks a condition in the cycle after its trigger, outside reset.
`define SDVPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sdvpm_pkg.sv
// Types and constants of the sampled DC, variance and pulse meter.
package sdvpm_pkg;

  // Field widths.
  localparam int SAMPLE_W = 12;
  localparam int EDGE_W   = 16;
  localparam int TOTAL_W  = 16;
  localparam int VAR_W    = 22;

  // Mean and variance are taken over a fixed pair of samples.
  localparam int PAIR_LEN   = 2;
  localparam int PAIR_SHIFT = $clog2(PAIR_LEN);
  localparam int PHASE_W    = (PAIR_SHIFT > 0) ? PAIR_SHIFT : 1;
  localparam int SQ_W       = 2 * SAMPLE_W + PAIR_SHIFT;
  localparam int SUM_W      = SAMPLE_W + PAIR_SHIFT;
  localparam logic [VAR_W-1:0] VAR_MAX = '1;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic ADDR_MEASURE_MODE  = 1'b0;
  localparam logic ADDR_MOVING_WINDOW = 1'b1;

  typedef enum logic [1:0] {
    MODE_DC    = 2'd0,
    MODE_PAIR  = 2'd1,
    MODE_IDLE  = 2'd2,
    MODE_PULSE = 2'd3
  } measure_mode_t;

  typedef struct packed {
    logic                tick_overflow;
    logic [SAMPLE_W-1:0] adc_sample;
    logic [EDGE_W-1:0]   edge_count;
  } sample_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] dc_level;
    logic [VAR_W-1:0]    variance_level;
    logic [EDGE_W-1:0]   pulses;
    logic                updated;
  } result_item_t;

endpackage

### src/sampled_dc_variance_pulse_meter_core.sv
// Sampled DC average, pair variance and pulse count meter: one timer tick per item.
// The block takes one item per clock cycle while sample_stall is low and returns one result
// item per input item through the update stage and output registers. The rate is set by the
// read-modify-write of the sample ring: the ring entry is read in the accept cycle and
// written back when the item leaves the update stage, through one read and one write port.
// The ring holds WINDOW_LEN samples with a valid bit per entry, so it needs no clearing pass
// after reset. Mode and window kind are to be written by the user through the APB port at
// byte addresses 0 and 4 only while no item is in flight; the block does not enforce it.
`include "sampled_dc_variance_pulse_meter_core_defines.svh"

module sampled_dc_variance_pulse_meter_core
  import sdvpm_pkg::*;
#(
  parameter int WINDOW_LEN = 16,
  parameter int DC_DIVIDE  = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  sample_item_t       sample,
  output logic               result_valid,
  input  logic               result_stall,
  output result_item_t       result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int POS_W       = $clog2(WINDOW_LEN);
  localparam int PRE_W       = (DC_DIVIDE > 1) ? $clog2(DC_DIVIDE) : 1;
  localparam int RECIP_SHIFT = TOTAL_W + POS_W;
  localparam int RECIP_W     = TOTAL_W + 1;
  localparam int PROD_W      = RECIP_SHIFT + SAMPLE_W;
  localparam logic [RECIP_W-1:0] RECIP_MULT =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
  localparam logic [PRE_W-1:0] LAST_PRE   = PRE_W'(DC_DIVIDE - 1);
  localparam logic [POS_W-1:0] LAST_POS   = POS_W'(WINDOW_LEN - 1);
  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(PAIR_LEN - 1);

  // Configuration registers.
  measure_mode_t measure_mode;
  logic          moving_window;
  logic          cfg_write;

  // Handshake.
  logic s1_valid;
  logic s1_move;
  logic s1_fire;
  logic accept;

  // Accept stage.
  logic [PRE_W-1:0] dc_prescale;
  logic [PRE_W-1:0] pre_next;
  logic [POS_W-1:0] window_pos;
  logic [POS_W-1:0] pos_next;
  logic             dc_count;
  logic             dc_go;

  // Update stage payload.
  sample_item_t     s1_item;
  logic             s1_dc_go;
  logic [POS_W-1:0] s1_pos;

  // Sample ring.
  logic [SAMPLE_W-1:0]   window_store [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] store_valid;
  logic [SAMPLE_W-1:0]   ring_rdata;
  logic                  old_ok;
  logic                  mem_we;

  // Held state.
  logic [TOTAL_W-1:0]  window_total, window_total_next;
  logic [SAMPLE_W-1:0] dc_hold, dc_hold_next;
  logic [PHASE_W-1:0]  pair_phase, pair_phase_next;
  logic [SQ_W-1:0]     square_total, square_total_next;
  logic [SUM_W-1:0]    sample_total, sample_total_next;
  logic [VAR_W-1:0]    variance_hold, variance_hold_next;
  logic [EDGE_W-1:0]   previous_edges, previous_edges_next;
  logic [EDGE_W-1:0]   pulse_hold, pulse_hold_next;
  logic                upd;

  // Datapath.
  logic [SAMPLE_W-1:0]   old_val;
  logic [TOTAL_W-1:0]    total_moving;
  logic [TOTAL_W-1:0]    total_block;
  logic [TOTAL_W-1:0]    div_in;
  logic [PROD_W-1:0]     div_prod;
  logic [SAMPLE_W-1:0]   dc_avg;
  logic [2*SAMPLE_W-1:0] val_sq;
  logic [SQ_W-1:0]       sq_sum;
  logic [SUM_W-1:0]      smp_sum;
  logic [PHASE_W-1:0]    phase_step;
  logic [SAMPLE_W-1:0]   pair_mean;
  logic [2*SAMPLE_W-1:0] mean_sq;
  logic [2*SAMPLE_W-1:0] sq_mean;
  logic [2*SAMPLE_W:0]   var_diff;
  logic [VAR_W-1:0]      var_sat;
  logic [EDGE_W-1:0]     pulse_diff;

  // Configuration writes and reads; the register index is the word address.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      measure_mode  <= MODE_DC;
      moving_window <= 1'b1;
    end else if (cfg_write) begin
      unique case (paddr[2])
        ADDR_MEASURE_MODE:  measure_mode  <= measure_mode_t'(pwdata[1:0]);
        ADDR_MOVING_WINDOW: moving_window <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      ADDR_MEASURE_MODE:  prdata = {{(PDATA_W-2){1'b0}}, measure_mode};
      ADDR_MOVING_WINDOW: prdata = {{(PDATA_W-1){1'b0}}, moving_window};
      default:            prdata = '0;
    endcase
  end

  // The update stage moves when the output register is empty or being taken.
  assign s1_move      = !result_valid || !result_stall;
  assign s1_fire      = s1_valid && s1_move;
  assign sample_stall = s1_valid && !s1_move;
  assign accept       = sample_valid && !sample_stall;

  // Prescaler steps per accepted DC tick, ring position on its wrap, for the ring read.
  assign pre_next = (dc_prescale == LAST_PRE) ? '0 : dc_prescale + 1'b1;
  assign pos_next = (window_pos == LAST_POS) ? '0 : window_pos + 1'b1;
  assign dc_count = sample.tick_overflow && (measure_mode == MODE_DC);
  assign dc_go    = dc_count && (pre_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      dc_prescale <= '0;
      window_pos  <= '0;
    end else if (accept && dc_count) begin
      dc_prescale <= pre_next;
      if (dc_go) begin
        window_pos <= pos_next;
      end
    end
  end

  // Update stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item  <= sample;
      s1_dc_go <= dc_go;
      s1_pos   <= pos_next;
    end
  end

  // Sample ring: read at acceptance, written back when the item leaves the update stage.
  // Consecutive averaging ticks always use neighboring entries, so a read never meets the
  // write of the same entry.
  assign mem_we = s1_fire && s1_dc_go && moving_window;

  always_ff @(posedge clk) begin
    if (accept) begin
      ring_rdata <= window_store[pos_next];
    end
    if (mem_we) begin
      window_store[s1_pos] <= s1_item.adc_sample;
    end
  end

  // An entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      store_valid <= '0;
    end else if (mem_we) begin
      store_valid[s1_pos] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      old_ok <= store_valid[pos_next];
    end
  end

  // Window sums and the division by the window length as a reciprocal multiply.
  assign old_val      = old_ok ? ring_rdata : '0;
  assign total_moving = window_total - TOTAL_W'(old_val) + TOTAL_W'(s1_item.adc_sample);
  assign total_block  = window_total + TOTAL_W'(s1_item.adc_sample);
  assign div_in       = moving_window ? total_moving : total_block;
  assign div_prod     = PROD_W'(div_in) * PROD_W'(RECIP_MULT);
  assign dc_avg       = div_prod[RECIP_SHIFT +: SAMPLE_W];

  // Pair sums, mean and variance with saturation.
  assign val_sq     = (2*SAMPLE_W)'(s1_item.adc_sample) * (2*SAMPLE_W)'(s1_item.adc_sample);
  assign sq_sum     = square_total + SQ_W'(val_sq);
  assign smp_sum    = sample_total + SUM_W'(s1_item.adc_sample);
  assign phase_step = (pair_phase == LAST_PHASE) ? '0 : pair_phase + 1'b1;
  assign pair_mean  = smp_sum[SUM_W-1 -: SAMPLE_W];
  assign mean_sq    = (2*SAMPLE_W)'(pair_mean) * (2*SAMPLE_W)'(pair_mean);
  assign sq_mean    = sq_sum[SQ_W-1 -: 2*SAMPLE_W];
  assign var_diff   = {1'b0, sq_mean} - {1'b0, mean_sq};
  assign var_sat    = (var_diff[2*SAMPLE_W:VAR_W] != '0) ? VAR_MAX : var_diff[VAR_W-1:0];

  // Edge counter difference wraps with the counter.
  assign pulse_diff = s1_item.edge_count - previous_edges;

  // Next values of the held state for the item in the update stage.
  always_comb begin
    window_total_next   = window_total;
    dc_hold_next        = dc_hold;
    pair_phase_next     = pair_phase;
    square_total_next   = square_total;
    sample_total_next   = sample_total;
    variance_hold_next  = variance_hold;
    previous_edges_next = previous_edges;
    pulse_hold_next     = pulse_hold;
    upd                 = 1'b0;
    if (s1_item.tick_overflow) begin
      unique case (measure_mode)
        MODE_DC: begin
          if (s1_dc_go) begin
            if (moving_window) begin
              window_total_next = total_moving;
              dc_hold_next      = dc_avg;
              upd               = 1'b1;
            end else if (s1_pos == '0) begin
              window_total_next = '0;
              dc_hold_next      = dc_avg;
              upd               = 1'b1;
            end else begin
              window_total_next = total_block;
            end
          end
        end
        MODE_PAIR: begin
          pair_phase_next = phase_step;
          if (phase_step == '0) begin
            square_total_next  = '0;
            sample_total_next  = '0;
            dc_hold_next       = pair_mean;
            variance_hold_next = var_sat;
            upd                = 1'b1;
          end else begin
            square_total_next = sq_sum;
            sample_total_next = smp_sum;
          end
        end
        MODE_IDLE: ;
        MODE_PULSE: begin
          pulse_hold_next     = pulse_diff;
          previous_edges_next = s1_item.edge_count;
          upd                 = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_total   <= '0;
      dc_hold        <= '0;
      pair_phase     <= '0;
      square_total   <= '0;
      sample_total   <= '0;
      variance_hold  <= '0;
      previous_edges <= '0;
      pulse_hold     <= '0;
    end else if (s1_fire) begin
      window_total   <= window_total_next;
      dc_hold        <= dc_hold_next;
      pair_phase     <= pair_phase_next;
      square_total   <= square_total_next;
      sample_total   <= sample_total_next;
      variance_hold  <= variance_hold_next;
      previous_edges <= previous_edges_next;
      pulse_hold     <= pulse_hold_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      result.dc_level       <= dc_hold_next;
      result.variance_level <= variance_hold_next;
      result.pulses         <= pulse_hold_next;
      result.updated        <= upd;
    end
  end

  // An accepted item always reaches the update stage.
  `SDVPM_ASSERT_NEXT(a_accept_fills_stage, accept, s1_valid, "accepted item did not enter the update stage")
  // While the update stage waits, the ring read data must stay put.
  `SDVPM_ASSERT_NEXT(a_stall_keeps_read, s1_valid && !s1_move, s1_valid && $stable(ring_rdata) && $stable(old_ok), "ring read data changed under a stall")
  // A finished update always shows up as a result item.
  `SDVPM_ASSERT_NEXT(a_fire_gives_result, s1_fire, result_valid, "update finished without a result item")
  // A ring read never targets the entry being written back in the same cycle.
  `SDVPM_ASSERT_NOW(a_ring_no_collision, accept && mem_we, pos_next != s1_pos, "ring read and write hit the same entry")

endmodule
